// ===== hw/rtl/fdf_pkg.sv =====
// ----------------------------------------------------------------------------
// fdf_pkg
// Shared types and constants of the fractional-delay FIR filter.
// ----------------------------------------------------------------------------
package fdf_pkg;

	localparam int TAPS_DEF   = 64;
	localparam int SMP_W      = 16;
	localparam int FRAC_W     = 16;
	localparam int CIDX_W     = 6;
	localparam int OUT_W      = 32;
	localparam int IN_TDATA_W = 56;
	localparam int SHIFT      = 15;

	typedef enum logic [1:0] {
		ACT_PUSH_FILT = 2'd0,
		ACT_PUSH      = 2'd1,
		ACT_FILT      = 2'd2,
		ACT_LOAD      = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_FILT,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic capture;
		logic clr;
		logic push;
		logic coef_wr;
		logic rd;
		logic first;
		logic tap;
		logic acc_clr;
		logic finish;
	} cmd_t;

	typedef struct packed {
		action_t action;
		logic    pipe_busy;
		logic    out_free;
	} status_t;

endpackage

// ===== hw/rtl/fdf_ram.sv =====
// ----------------------------------------------------------------------------
// fdf_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fdf_ram #(
	parameter int W     = 16,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/fdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// fdf_ctrl
// Controller: store clearing after reset, action sequencing, tap counter.
// ----------------------------------------------------------------------------
module fdf_ctrl #(
	parameter int TAPS  = fdf_pkg::TAPS_DEF,
	localparam int CNT_W = $clog2(TAPS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  fdf_pkg::status_t status,
	output fdf_pkg::cmd_t    cmd,
	output logic [CNT_W-1:0] cnt
);

	import fdf_pkg::*;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TAPS);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (cnt_q == CNT_LAST) begin
					cnt_d   = '0;
					state_d = ST_IDLE;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cnt_d = '0;
				case (status.action)
					ACT_LOAD: begin
						cmd.coef_wr = 1'b1;
						state_d     = ST_IDLE;
					end
					ACT_PUSH: begin
						cmd.push = 1'b1;
						state_d  = ST_IDLE;
					end
					ACT_PUSH_FILT: begin
						cmd.push = 1'b1;
						state_d  = ST_FILT;
					end
					ACT_FILT: begin
						state_d = ST_FILT;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_FILT: begin
				cmd.rd      = 1'b1;
				cmd.first   = (cnt_q == '0);
				cmd.acc_clr = (cnt_q == '0);
				cmd.tap     = (cnt_q != '0);
				if (cnt_q == CNT_LAST) begin
					cnt_d   = '0;
					state_d = ST_DRAIN;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy && status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign cnt = cnt_q;

endmodule

// ===== hw/rtl/fdf_datapath.sv =====
// ----------------------------------------------------------------------------
// fdf_datapath
// Sample and coefficient stores, interpolate and multiply-accumulate pipeline,
// output register.
// ----------------------------------------------------------------------------
module fdf_datapath #(
	parameter int TAPS  = fdf_pkg::TAPS_DEF,
	localparam int CNT_W = $clog2(TAPS + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fdf_pkg::cmd_t                    cmd,
	input  logic [CNT_W-1:0]                 cnt,
	output fdf_pkg::status_t                 status,
	input  logic [fdf_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  logic [1:0]                       s_tuser,
	input  logic                             m_tready,
	output logic                             m_tvalid,
	output logic [fdf_pkg::OUT_W-1:0]        m_tdata
);

	import fdf_pkg::*;

	localparam int SA_W  = $clog2(TAPS + 1);
	localparam int CA_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int ACC_W = 32 + $clog2(TAPS);
	localparam int PR_W  = 2 * (SMP_W + 1);
	localparam logic [SA_W-1:0] SA_LAST = SA_W'(TAPS);

	action_t                    act_q;
	logic signed [SMP_W-1:0]    smp_q;
	logic [FRAC_W-1:0]          frac_q;
	logic [CIDX_W-1:0]          cidx_q;
	logic signed [SMP_W-1:0]    cval_q;

	logic [SA_W-1:0]            wr_idx_q, wr_idx_nx;
	logic [SA_W-1:0]            rd_addr_q, rd_addr_nx, s_raddr;
	logic                       s_we;
	logic [SA_W-1:0]            s_waddr;
	logic [SMP_W-1:0]           s_wdata, s_rdata;
	logic                       c_we;
	logic [CA_W-1:0]            c_waddr, c_raddr;
	logic [SMP_W-1:0]           c_wdata, c_rdata;
	logic [CNT_W-1:0]           cnt_m1;
	logic                       cidx_ok;

	logic                       rdv_q, v_s1, v_s2;
	logic signed [SMP_W-1:0]    s_prev_q;
	logic signed [SMP_W:0]      diff;
	logic signed [PR_W-1:0]     prod;
	logic signed [PR_W-1:0]     prod_s1;
	logic signed [SMP_W-1:0]    sold_s1, coef_s1;
	logic signed [SMP_W+1:0]    interp_w;
	logic signed [SMP_W-1:0]    interp;
	logic signed [2*SMP_W-1:0]  mul_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       out_valid_q;
	logic [OUT_W-1:0]           out_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q  <= action_t'(s_tuser);
			smp_q  <= s_tdata[15:0];
			frac_q <= s_tdata[31:16];
			cidx_q <= s_tdata[37:32];
			cval_q <= s_tdata[53:38];
		end
	end

	assign wr_idx_nx  = (wr_idx_q == SA_LAST) ? '0 : wr_idx_q + SA_W'(1);
	assign rd_addr_nx = (rd_addr_q == SA_LAST) ? '0 : rd_addr_q + SA_W'(1);
	assign s_raddr    = cmd.first ? wr_idx_q : rd_addr_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
		end else if (cmd.push) begin
			wr_idx_q <= wr_idx_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_addr_q <= s_raddr;
		end
	end

	assign s_we    = cmd.clr | cmd.push;
	assign s_waddr = cmd.clr ? SA_W'(cnt) : wr_idx_q;
	assign s_wdata = cmd.clr ? '0 : smp_q;

	assign cidx_ok = 32'(cidx_q) < TAPS;
	assign cnt_m1  = cnt - CNT_W'(1);
	assign c_we    = (cmd.clr && (32'(cnt) < TAPS)) || (cmd.coef_wr && cidx_ok);
	assign c_waddr = cmd.clr ? CA_W'(cnt) : CA_W'(cidx_q);
	assign c_wdata = cmd.clr ? '0 : cval_q;
	assign c_raddr = CA_W'(cnt_m1);

	fdf_ram #(.W(SMP_W), .DEPTH(TAPS + 1)) u_smp_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	fdf_ram #(.W(SMP_W), .DEPTH(TAPS)) u_coef_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	// interp = old + floor((new - old) * frac / 2^16)
	assign diff = $signed({s_rdata[SMP_W-1], s_rdata}) - $signed({s_prev_q[SMP_W-1], s_prev_q});
	assign prod = diff * $signed({1'b0, frac_q});

	assign interp_w = $signed({{2{sold_s1[SMP_W-1]}}, sold_s1}) + prod_s1[PR_W-1:FRAC_W];
	assign interp   = interp_w[SMP_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_q <= 1'b0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			rdv_q <= cmd.tap;
			v_s1  <= rdv_q;
			v_s2  <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		s_prev_q <= s_rdata;
		prod_s1  <= prod;
		sold_s1  <= s_prev_q;
		coef_s1  <= c_rdata;
		mul_s2   <= coef_s1 * interp;
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(mul_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q <= OUT_W'($signed(acc_q[ACC_W-1:SHIFT]));
		end
	end

	assign status.action    = act_q;
	assign status.pipe_busy = rdv_q | v_s1 | v_s2;
	assign status.out_free  = ~out_valid_q | m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

// ===== hw/rtl/fir_filter_fractional_delay_unit.sv =====
// Filter words (push and filter, filter only): the unit makes one interpolate and
// multiply-accumulate pass per tap through the single read port of each store, drains
// the pipeline, then loads the output register and raises m_tvalid once that register
// is free; only then is the next word taken. Push-only and coefficient-load words are
// done in the EXEC state. After reset, s_tready stays low while both stores are zeroed.
// ----------------------------------------------------------------------------
// fir_filter_fractional_delay_unit
// FIR filter with linearly interpolated fractional-delay taps.
// ----------------------------------------------------------------------------
module fir_filter_fractional_delay_unit #(
	parameter int TAPS = fdf_pkg::TAPS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// sample[15:0], fraction[31:16], coef_index[37:32], coef_value[53:38], zero[55:54]
	input  logic [fdf_pkg::IN_TDATA_W-1:0]  s_tdata,
	// action[1:0]
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// filtered[31:0]
	output logic [fdf_pkg::OUT_W-1:0]       m_tdata
);

	import fdf_pkg::*;

	localparam int CNT_W = $clog2(TAPS + 1);

	cmd_t             cmd;
	status_t          status;
	logic [CNT_W-1:0] cnt;

	fdf_ctrl #(.TAPS(TAPS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd),
		.cnt      (cnt)
	);

	fdf_datapath #(.TAPS(TAPS)) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cnt      (cnt),
		.status   (status),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== test/fir_filter_fractional_delay_unit_tb.sv =====
// ----------------------------------------------------------------------------
// fir_filter_fractional_delay_unit_tb
// Self-checking bench: drives push, filter and coefficient-load words with
// random gaps, keeps its own copy of the sample and coefficient stores to
// predict every filter output, and compares each output word in order.
// ----------------------------------------------------------------------------
class fdf_scoreboard;
	localparam int TAPS = fdf_pkg::TAPS_DEF;

	int          hist [TAPS+1];
	int          taps_q15 [TAPS];
	int          wr_slot;
	logic [31:0] expected_out [$];
	int          mismatches;

	function new();
		foreach (hist[i]) hist[i] = 0;
		foreach (taps_q15[i]) taps_q15[i] = 0;
		wr_slot    = 0;
		mismatches = 0;
	endfunction

	function void flag(string what, logic [31:0] exp_val, logic [31:0] got_val);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s expected %h actual %h", $realtime, what, exp_val, got_val);
	endfunction

	function logic [31:0] filter_output(logic [15:0] frac);
		longint acc, mix, interp, keep;
		int     older, newer;
		acc   = 0;
		keep  = 65536 - longint'(frac);
		older = wr_slot;
		for (int i = 0; i < TAPS; i++) begin
			newer  = (older == TAPS) ? 0 : older + 1;
			mix    = longint'(hist[older]) * keep + longint'(hist[newer]) * longint'(frac);
			interp = mix >>> 16;
			acc   += longint'(taps_q15[i]) * interp;
			older  = newer;
		end
		acc = acc >>> 15;
		if (acc > 64'sd2147483647)
			acc = 64'sd2147483647;
		if (acc < -64'sd2147483648)
			acc = -64'sd2147483648;
		return acc[31:0];
	endfunction

	function void note_input(fdf_pkg::action_t act, logic signed [15:0] smp,
			logic [15:0] frac, logic [5:0] cidx, logic signed [15:0] cval);
		if (act == fdf_pkg::ACT_LOAD) begin
			if (int'(cidx) < TAPS)
				taps_q15[cidx] = int'(cval);
			return;
		end
		if (act == fdf_pkg::ACT_PUSH_FILT || act == fdf_pkg::ACT_PUSH) begin
			hist[wr_slot] = int'(smp);
			wr_slot = (wr_slot == TAPS) ? 0 : wr_slot + 1;
		end
		if (act != fdf_pkg::ACT_PUSH)
			expected_out = {expected_out, filter_output(frac)};
	endfunction

	function void check_result(logic [31:0] got);
		logic [31:0] want;
		if (expected_out.size() == 0) begin
			flag("unexpected filtered word", 32'h0, got);
			return;
		end
		want = expected_out.pop_front();
		if (got !== want)
			flag("filtered", want, got);
	endfunction
endclass

module fir_filter_fractional_delay_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fdf_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic [1:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_W-1:0]      m_tdata;

	fdf_scoreboard sb = new();
	int            results_seen = 0;
	bit            hold_sink = 1'b0;
	bit            burst_mode = 1'b0;

	fir_filter_fractional_delay_unit #(.TAPS(TAPS_DEF)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		if (burst_mode)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] pick16();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_word(action_t act, logic [15:0] smp, logic [15:0] frac,
			logic [5:0] cidx, logic [15:0] cval);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {2'b00, cval, cidx, frac, smp};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_input(act, smp, frac, cidx, cval);
	endtask

	task automatic send_random();
		int      r;
		action_t act;
		r = $urandom_range(0, 99);
		if (r < 20)
			act = ACT_LOAD;
		else if (r < 40)
			act = ACT_PUSH;
		else if (r < 75)
			act = ACT_PUSH_FILT;
		else
			act = ACT_FILT;
		send_word(act, pick16(), pick16(), 6'($urandom), pick16());
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			sb.check_result(m_tdata);
			results_seen <= results_seen + 1;
		end
	end

	initial begin : sink
		int stall;
		int cyc;
		stall = 0;
		cyc   = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_sink) begin
				m_tready <= 1'b0;
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				if ((cyc / 3000) % 4 != 0 && $urandom_range(0, 99) < 20)
					stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 4);
			end
		end
	end

	initial begin : backpressure
		wait (results_seen >= 100);
		@(posedge clk);
		hold_sink = 1'b1;
		repeat (600) @(posedge clk);
		hold_sink = 1'b0;
	end

	initial begin : timeout
		#30_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		int n;
		int drain;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		send_word(ACT_LOAD, pick16(), pick16(), 6'd0, 16'h7FFF);
		send_word(ACT_LOAD, pick16(), pick16(), 6'd63, 16'h8000);
		send_word(ACT_LOAD, pick16(), pick16(), 6'd31, 16'hFFFF);
		send_word(ACT_LOAD, pick16(), pick16(), 6'd1, 16'h8000);
		send_word(ACT_FILT, pick16(), 16'h0000, 6'($urandom), pick16());
		send_word(ACT_PUSH, 16'h7FFF, pick16(), 6'($urandom), pick16());
		send_word(ACT_PUSH, 16'h8000, pick16(), 6'($urandom), pick16());
		send_word(ACT_PUSH_FILT, 16'h7FFF, 16'h0000, 6'($urandom), pick16());
		send_word(ACT_FILT, pick16(), 16'hFFFF, 6'($urandom), pick16());
		send_word(ACT_FILT, pick16(), 16'h8000, 6'($urandom), pick16());
		send_word(ACT_FILT, pick16(), 16'h0001, 6'($urandom), pick16());
		send_word(ACT_PUSH_FILT, 16'h8000, 16'hFFFF, 6'($urandom), pick16());
		send_word(ACT_PUSH_FILT, 16'h0000, 16'h0000, 6'($urandom), pick16());
		send_word(ACT_LOAD, pick16(), pick16(), 6'd62, 16'h7FFF);
		send_word(ACT_PUSH, 16'hFFFF, pick16(), 6'($urandom), pick16());
		send_word(ACT_PUSH_FILT, 16'h0001, 16'h8000, 6'($urandom), pick16());
		send_word(ACT_FILT, pick16(), 16'hFFFF, 6'($urandom), pick16());

		for (n = 0; n < 1200; n++) begin
			if (n % 100 == 0)
				burst_mode = ($urandom_range(0, 3) == 0);
			send_random();
		end

		burst_mode = 1'b1;
		for (n = 0; n < TAPS_DEF; n++)
			send_word(ACT_LOAD, pick16(), pick16(), 6'(n), 16'h8000);
		for (n = 0; n <= TAPS_DEF; n++)
			send_word(ACT_PUSH, 16'h8000, pick16(), 6'($urandom), pick16());
		send_word(ACT_FILT, pick16(), 16'h0000, 6'($urandom), pick16());
		send_word(ACT_FILT, pick16(), 16'hFFFF, 6'($urandom), pick16());
		send_word(ACT_PUSH_FILT, 16'h7FFF, 16'h8000, 6'($urandom), pick16());
		burst_mode = 1'b0;

		for (n = 0; n < 200; n++)
			send_random();

		s_tvalid <= 1'b0;
		drain = 0;
		while (sb.expected_out.size() != 0 && drain < 100000) begin
			@(posedge clk);
			drain++;
		end
		repeat (TAPS_DEF + 16) @(posedge clk);
		if (sb.expected_out.size() != 0)
			sb.flag("missing filtered words", 32'(sb.expected_out.size()), 32'h0);
		if (sb.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
